// File: hdl/sha256_compression_top_defines.svh
// assertion macros shared by the sha-256 compression block
// relies on i_clk and i_rst_n being present in the module that uses them
`ifndef SHA256_COMPRESSION_TOP_DEFINES_SVH
`define SHA256_COMPRESSION_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha256 assertion failed");

// next-cycle implication, checked outside reset
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha256 assertion failed");

`endif

// File: hdl/sha256c_pkg.sv
// shared types, constants and round functions of the sha-256 compression block
// no dependencies
package sha256c_pkg;

    typedef logic [31:0] t_word;

    localparam logic [3:0] LAST_WORD_IDX = 4'd15;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_DIGEST   = 3'd7;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load_word;
        logic       load_iv;
        logic       init_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_chain;
        logic [2:0] out_idx;
    } t_dp_cmd;

    function automatic t_word init_hash(input logic [2:0] idx);
        t_word v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_word round_const(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: hdl/sha256_compression_top.sv
// sha-256 compression block, top level: controller plus datapath
// depends on sha256c_pkg, sha256c_ctrl and sha256c_dp
//
// usage
//   input channel: one padded big-endian message word per request
//   (i_message_word, i_start_of_message, i_end_of_message), taken when
//   i_valid is high and o_stall is low. start reloads the initial hash
//   value and restarts the word count; end only matters on word 16 of a block.
//   output channel: eight digest requests (o_digest_word, o_word_index,
//   o_last_word), taken when o_valid is high and i_stall is low.
//   timing
//   - words 1 to 15 of a block are taken one per cycle
//   - word 16 starts 64 rounds, one per cycle on the shared round logic,
//     then the add state adds the working variables into the chaining value;
//     o_stall stays high through the rounds and the add state
//   - with the end flag, the digest words are offered after the add state,
//     one word per cycle while i_stall is low; input stays stalled until
//     the eighth word is taken
//   a high i_stall holds the current digest word and index in place.
//   reset loads the initial hash value and clears the word count; the
//   schedule window holds no defined value until a full block was written.
module sha256_compression_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_start_of_message,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha256c_pkg::*;

    // command bundle from the sequencer to the datapath
    t_dp_cmd w_cmd;

    // controller: counts words, steps the 64 rounds, walks out the digest
    sha256c_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_start_of_message (i_start_of_message),
        .i_end_of_message   (i_end_of_message),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_word_index       (o_word_index),
        .o_last_word        (o_last_word),
        .o_cmd              (w_cmd)
    );

    // datapath: hash state, schedule window and one round per cycle
    sha256c_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_message_word (i_message_word),
        .o_digest_word  (o_digest_word)
    );

endmodule

// File: hdl/sha256c_dp.sv
// datapath: chaining value, working variables, schedule shift window, round logic
// depends on sha256c_pkg
module sha256c_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256c_pkg::t_dp_cmd i_cmd,
    input  sha256c_pkg::t_word  i_message_word,
    output sha256c_pkg::t_word  o_digest_word
);
    import sha256c_pkg::*;

    t_word r_chain [8];
    t_word r_work  [8];
    t_word r_sched [16];

    t_word n_sched_new;
    t_word n_t1;
    t_word n_t2;
    t_word n_ch;
    t_word n_maj;

    // next schedule word, pushed at the tail each round
    assign n_sched_new = small_sigma1(r_sched[14]) + r_sched[9]
                       + small_sigma0(r_sched[1]) + r_sched[0];

    assign n_ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign n_maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                 ^ (r_work[1] & r_work[2]);
    assign n_t1  = r_work[7] + big_sigma1(r_work[4]) + n_ch
                 + round_const(i_cmd.round_idx) + r_sched[0];
    assign n_t2  = big_sigma0(r_work[0]) + n_maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else if (i_cmd.load_iv) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else if (i_cmd.add_chain) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= '0;
            end
        end else if (i_cmd.init_work) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.round_en) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + n_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= n_t1 + n_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            for (int i = 0; i < 15; i++) begin
                r_sched[i] <= r_sched[i + 1];
            end
            r_sched[15] <= i_message_word;
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_sched[i] <= r_sched[i + 1];
            end
            r_sched[15] <= n_sched_new;
        end
    end

    assign o_digest_word = r_chain[i_cmd.out_idx];

endmodule

// File: hdl/sha256c_ctrl.sv
// controller: word count, round sequencing and digest output sequencing
// depends on sha256c_pkg and sha256_compression_top_defines.svh
`include "sha256_compression_top_defines.svh"

module sha256c_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_start_of_message,
    input  logic                 i_end_of_message,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word,
    output sha256c_pkg::t_dp_cmd o_cmd
);
    import sha256c_pkg::*;

    typedef enum logic [1:0] {
        S_FILL,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_cnt;
    logic [5:0] r_round;
    logic [2:0] r_out_idx;
    logic       r_end;

    logic       n_accept;
    logic [3:0] n_widx;
    logic       n_block_done;
    logic       n_out_take;

    assign n_accept     = i_valid && (r_state == S_FILL);
    assign n_widx       = i_start_of_message ? 4'd0 : r_cnt;
    assign n_block_done = n_accept && (n_widx == LAST_WORD_IDX);
    assign n_out_take   = (r_state == S_OUT) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_cnt     <= '0;
            r_round   <= '0;
            r_out_idx <= '0;
            r_end     <= 1'b0;
        end else begin
            unique case (r_state)
                S_FILL: begin
                    if (n_accept) begin
                        r_cnt <= n_widx + 4'd1;
                        if (n_block_done) begin
                            r_end   <= i_end_of_message;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_out_idx <= '0;
                    r_state   <= r_end ? S_OUT : S_FILL;
                end
                S_OUT: begin
                    if (n_out_take) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == LAST_DIGEST) begin
                            r_state <= S_FILL;
                        end
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    assign o_stall      = (r_state != S_FILL);
    assign o_valid      = (r_state == S_OUT);
    assign o_word_index = r_out_idx;
    assign o_last_word  = (r_out_idx == LAST_DIGEST);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_word = n_accept;
        o_cmd.load_iv   = n_accept && i_start_of_message;
        o_cmd.init_work = n_block_done;
        o_cmd.round_en  = (r_state == S_ROUND);
        o_cmd.round_idx = r_round;
        o_cmd.add_chain = (r_state == S_ADD);
        o_cmd.out_idx   = r_out_idx;
    end

    `SHA_ASSERT_NEXT(a_round_to_add, (r_state == S_ROUND) && (r_round == LAST_ROUND), r_state == S_ADD)
    `SHA_ASSERT_NEXT(a_add_no_end, (r_state == S_ADD) && !r_end, (r_state == S_FILL) && (r_cnt == 4'd0))
    `SHA_ASSERT_NEXT(a_last_out_done, n_out_take && o_last_word, r_state == S_FILL)
    `SHA_ASSERT_NOW(a_round_idle_zero, r_state != S_ROUND, r_round == 6'd0)

endmodule
